/* src/cfpr_pkg.sv */
// Shared types, constants and command codes of the cubic false-position root finder.
package cfpr_pkg;

    localparam int DATA_WIDTH    = 32;
    localparam int FRACTION_BITS = 20;
    localparam int PROD_WIDTH    = 2 * DATA_WIDTH;
    localparam int DIV_STEPS     = PROD_WIDTH;
    localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);
    localparam int TOL_WIDTH     = 31;
    localparam int LIMIT_WIDTH   = 8;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 32;

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_COEFF_CUBIC     = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_COEFF_SQUARE    = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_COEFF_LINEAR    = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_COEFF_CONSTANT  = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TOLERANCE       = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ITERATION_LIMIT = 3'd5;

    localparam logic [TOL_WIDTH-1:0]   TOL_RESET   = 31'd10;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 8'd64;

    typedef enum logic [1:0] {
        ST_CONVERGED  = 2'd0,
        ST_NO_BRACKET = 2'd1,
        ST_LIMIT      = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_MUL, OP_ADD, OP_SET_F1, OP_SET_F2, OP_CMUL1,
        OP_CMUL2, OP_NUM, OP_DIV, OP_QUOT, OP_UPDATE, OP_RESULT
    } dp_op_t;

    typedef enum logic [1:0] {
        COEF_SQUARE, COEF_LINEAR, COEF_CONSTANT
    } coef_sel_t;

    typedef enum logic [1:0] {
        PH_END1, PH_END2, PH_ITER
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ADD, S_SET_F1, S_SET_F2, S_BRACKET, S_CMUL1, S_CMUL2,
        S_NUM, S_DIV, S_QUOT, S_UPDATE, S_DONE
    } state_t;

    typedef struct packed {
        dp_op_t    op;
        coef_sel_t coef;
        logic      zero_root;
    } dp_cmd_t;

    typedef struct packed {
        logic no_bracket;
        logic converged;
    } dp_status_t;

endpackage

/* src/cfpr_datapath.sv */
// Datapath: coefficient registers, shared multiplier, Horner adder and restoring divider.
module cfpr_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [cfpr_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
    input  logic [cfpr_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    input  cfpr_pkg::data_t                        lower_bound,
    input  cfpr_pkg::data_t                        upper_bound,
    input  cfpr_pkg::dp_cmd_t                      cmd,
    output cfpr_pkg::dp_status_t                   status,
    output cfpr_pkg::data_t                        root
);
    import cfpr_pkg::*;

    localparam int SHR_WIDTH = PROD_WIDTH - FRACTION_BITS;

    localparam data_t DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    data_t c3_reg, c2_reg, c1_reg, c0_reg;
    logic [TOL_WIDTH-1:0] tol_reg;
    data_t x1_reg, x2_reg, f1_reg, f2_reg, x_reg, acc_reg, root_reg;
    logic [PROD_WIDTH-1:0] prod_reg, p_reg, nq_reg;
    logic mneg_reg, pn_reg, qn_reg, qneg_reg;
    logic [DATA_WIDTH:0] rem_reg, dm_reg;

    logic [DATA_WIDTH-1:0] mul_a, mul_b;
    logic [PROD_WIDTH-1:0] mul_p;
    logic [SHR_WIDTH-1:0]  shifted, mlim;
    data_t fm, coef, fa, qs;
    logic [DATA_WIDTH:0] sum;
    logic [PROD_WIDTH-1:0] num, qlim;
    logic nn, dn;
    logic [DATA_WIDTH:0] dm;
    logic [DATA_WIDTH+1:0] trial;
    logic ge;
    logic repl1;

    function automatic logic [DATA_WIDTH-1:0] mag(input data_t v);
        mag = v[DATA_WIDTH-1] ? DATA_WIDTH'(-v) : DATA_WIDTH'(v);
    endfunction

    always_comb begin
        case (cmd.op)
            OP_CMUL1: begin
                mul_a = mag(x1_reg);
                mul_b = mag(f2_reg);
            end
            OP_CMUL2: begin
                mul_a = mag(x2_reg);
                mul_b = mag(f1_reg);
            end
            default: begin
                mul_a = mag(acc_reg);
                mul_b = mag(x_reg);
            end
        endcase
    end

    assign mul_p = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);

    always_comb begin
        shifted = prod_reg[PROD_WIDTH-1:FRACTION_BITS];
        mlim = mneg_reg ? (SHR_WIDTH'(1) << (DATA_WIDTH-1))
                        : SHR_WIDTH'(DMAX);
        if (shifted > mlim) begin
            fm = mneg_reg ? DMIN : DMAX;
        end else if (mneg_reg) begin
            fm = -data_t'(shifted[DATA_WIDTH-1:0]);
        end else begin
            fm = data_t'(shifted[DATA_WIDTH-1:0]);
        end
        case (cmd.coef)
            COEF_SQUARE:   coef = c2_reg;
            COEF_LINEAR:   coef = c1_reg;
            COEF_CONSTANT: coef = c0_reg;
            default:       coef = c0_reg;
        endcase
        sum = {fm[DATA_WIDTH-1], fm} + {coef[DATA_WIDTH-1], coef};
        if (sum[DATA_WIDTH] != sum[DATA_WIDTH-1]) begin
            fa = sum[DATA_WIDTH] ? DMIN : DMAX;
        end else begin
            fa = sum[DATA_WIDTH-1:0];
        end
    end

    always_comb begin
        if (pn_reg != qn_reg) begin
            num = p_reg + prod_reg;
            nn  = pn_reg;
        end else if (p_reg >= prod_reg) begin
            num = p_reg - prod_reg;
            nn  = pn_reg;
        end else begin
            num = prod_reg - p_reg;
            nn  = !pn_reg;
        end
        if (f2_reg >= f1_reg) begin
            dm = {f2_reg[DATA_WIDTH-1], f2_reg} - {f1_reg[DATA_WIDTH-1], f1_reg};
            dn = 1'b0;
        end else begin
            dm = {f1_reg[DATA_WIDTH-1], f1_reg} - {f2_reg[DATA_WIDTH-1], f2_reg};
            dn = 1'b1;
        end
        trial = {rem_reg, nq_reg[PROD_WIDTH-1]};
        ge = trial >= {1'b0, dm_reg};
        qlim = qneg_reg ? (PROD_WIDTH'(1) << (DATA_WIDTH-1)) : PROD_WIDTH'(DMAX);
        if (nq_reg > qlim) begin
            qs = qneg_reg ? DMIN : DMAX;
        end else if (qneg_reg) begin
            qs = -data_t'(nq_reg[DATA_WIDTH-1:0]);
        end else begin
            qs = data_t'(nq_reg[DATA_WIDTH-1:0]);
        end
        repl1 = (acc_reg > 0 && f1_reg > 0) || (acc_reg < 0 && f1_reg < 0);
    end

    assign status.converged  = mag(acc_reg) < DATA_WIDTH'(tol_reg);
    assign status.no_bracket = !((f1_reg > 0 && f2_reg < 0) || (f1_reg < 0 && f2_reg > 0));
    assign root = root_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c3_reg  <= '0;
            c2_reg  <= '0;
            c1_reg  <= '0;
            c0_reg  <= '0;
            tol_reg <= TOL_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_COEFF_CUBIC:    c3_reg  <= data_t'(cfg_data);
                REG_COEFF_SQUARE:   c2_reg  <= data_t'(cfg_data);
                REG_COEFF_LINEAR:   c1_reg  <= data_t'(cfg_data);
                REG_COEFF_CONSTANT: c0_reg  <= data_t'(cfg_data);
                REG_TOLERANCE:      tol_reg <= cfg_data[TOL_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                x1_reg  <= lower_bound;
                x2_reg  <= upper_bound;
                x_reg   <= lower_bound;
                acc_reg <= c3_reg;
            end
            OP_MUL: begin
                prod_reg <= mul_p;
                mneg_reg <= acc_reg[DATA_WIDTH-1] ^ x_reg[DATA_WIDTH-1];
            end
            OP_ADD: acc_reg <= fa;
            OP_SET_F1: begin
                f1_reg  <= acc_reg;
                x_reg   <= x2_reg;
                acc_reg <= c3_reg;
            end
            OP_SET_F2: f2_reg <= acc_reg;
            OP_CMUL1: begin
                prod_reg <= mul_p;
                pn_reg   <= x1_reg[DATA_WIDTH-1] ^ f2_reg[DATA_WIDTH-1];
            end
            OP_CMUL2: begin
                p_reg    <= prod_reg;
                prod_reg <= mul_p;
                qn_reg   <= x2_reg[DATA_WIDTH-1] ^ f1_reg[DATA_WIDTH-1];
            end
            OP_NUM: begin
                nq_reg   <= num;
                rem_reg  <= '0;
                dm_reg   <= dm;
                qneg_reg <= nn ^ dn;
            end
            OP_DIV: begin
                rem_reg <= ge ? (DATA_WIDTH+1)'(trial - {1'b0, dm_reg})
                              : trial[DATA_WIDTH:0];
                nq_reg  <= {nq_reg[PROD_WIDTH-2:0], ge};
            end
            OP_QUOT: begin
                x_reg   <= (dm_reg == '0) ? x2_reg : qs;
                acc_reg <= c3_reg;
            end
            OP_UPDATE: begin
                if (repl1) begin
                    x1_reg <= x_reg;
                    f1_reg <= acc_reg;
                end else begin
                    x2_reg <= x_reg;
                    f2_reg <= acc_reg;
                end
            end
            OP_RESULT: root_reg <= cmd.zero_root ? '0 : x_reg;
            default: ;
        endcase
    end

endmodule

/* src/cfpr_ctrl.sv */
// Controller: sequences evaluations, chord steps and divides, and holds the result handshake.
module cfpr_ctrl (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [cfpr_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
    input  logic [cfpr_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [1:0]                             m_status,
    output logic [cfpr_pkg::LIMIT_WIDTH-1:0]       m_iterations_used,
    output cfpr_pkg::dp_cmd_t                      cmd,
    input  cfpr_pkg::dp_status_t                   status
);
    import cfpr_pkg::*;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    coef_sel_t coef_reg, coef_next;
    logic [DIV_CNT_WIDTH-1:0] div_cnt_reg, div_cnt_next;
    logic [LIMIT_WIDTH-1:0] n_reg, n_next;
    logic [LIMIT_WIDTH-1:0] limit_reg;
    status_t pend_reg, pend_next;
    logic m_valid_reg, m_valid_next;
    status_t out_status_reg, out_status_next;
    logic [LIMIT_WIDTH-1:0] out_iter_reg, out_iter_next;
    logic [LIMIT_WIDTH:0] n_inc;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_status = out_status_reg;
    assign m_iterations_used = out_iter_reg;
    assign n_inc = {1'b0, n_reg} + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_we && cfg_index == REG_ITERATION_LIMIT) begin
            limit_reg <= cfg_data[LIMIT_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_END1;
            coef_reg       <= COEF_SQUARE;
            div_cnt_reg    <= '0;
            n_reg          <= '0;
            pend_reg       <= ST_CONVERGED;
            m_valid_reg    <= 1'b0;
            out_status_reg <= ST_CONVERGED;
            out_iter_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            coef_reg       <= coef_next;
            div_cnt_reg    <= div_cnt_next;
            n_reg          <= n_next;
            pend_reg       <= pend_next;
            m_valid_reg    <= m_valid_next;
            out_status_reg <= out_status_next;
            out_iter_reg   <= out_iter_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        coef_next       = coef_reg;
        div_cnt_next    = div_cnt_reg;
        n_next          = n_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_status_next = out_status_reg;
        out_iter_next   = out_iter_reg;
        cmd.op          = OP_NONE;
        cmd.coef        = coef_reg;
        cmd.zero_root   = (pend_reg == ST_NO_BRACKET);
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    phase_next = PH_END1;
                    coef_next  = COEF_SQUARE;
                    n_next     = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.op     = OP_MUL;
                state_next = S_ADD;
            end
            S_ADD: begin
                cmd.op = OP_ADD;
                if (coef_reg == COEF_CONSTANT) begin
                    coef_next = COEF_SQUARE;
                    case (phase_reg)
                        PH_END1: state_next = S_SET_F1;
                        PH_END2: state_next = S_SET_F2;
                        default: state_next = S_UPDATE;
                    endcase
                end else begin
                    coef_next  = coef_sel_t'(coef_reg + 2'd1);
                    state_next = S_MUL;
                end
            end
            S_SET_F1: begin
                cmd.op     = OP_SET_F1;
                phase_next = PH_END2;
                state_next = S_MUL;
            end
            S_SET_F2: begin
                cmd.op     = OP_SET_F2;
                state_next = S_BRACKET;
            end
            S_BRACKET: begin
                if (status.no_bracket) begin
                    pend_next  = ST_NO_BRACKET;
                    state_next = S_DONE;
                end else begin
                    phase_next = PH_ITER;
                    state_next = S_CMUL1;
                end
            end
            S_CMUL1: begin
                cmd.op     = OP_CMUL1;
                state_next = S_CMUL2;
            end
            S_CMUL2: begin
                cmd.op     = OP_CMUL2;
                state_next = S_NUM;
            end
            S_NUM: begin
                cmd.op       = OP_NUM;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.op       = OP_DIV;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_WIDTH'(DIV_STEPS - 1)) begin
                    state_next = S_QUOT;
                end
            end
            S_QUOT: begin
                cmd.op     = OP_QUOT;
                state_next = S_MUL;
            end
            S_UPDATE: begin
                cmd.op = OP_UPDATE;
                n_next = n_inc[LIMIT_WIDTH-1:0];
                if (status.converged) begin
                    pend_next  = ST_CONVERGED;
                    state_next = S_DONE;
                end else if (n_inc >= {1'b0, limit_reg}) begin
                    pend_next  = ST_LIMIT;
                    state_next = S_DONE;
                end else begin
                    state_next = S_CMUL1;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.op          = OP_RESULT;
                    m_valid_next    = 1'b1;
                    out_status_next = pend_reg;
                    out_iter_next   = n_reg;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_MUL && phase_reg == PH_END1))
        else $error("transfer did not start an evaluation");

    a_nobr_iter: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_NO_BRACKET) |-> (m_iterations_used == '0))
        else $error("no-bracket result with nonzero iteration count");

    a_iter_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_NO_BRACKET) |-> (m_iterations_used != '0))
        else $error("chord result with zero iterations");

    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_NUM) |=> (state_reg == S_DIV && div_cnt_reg == '0))
        else $error("divide did not start from step zero");

endmodule

/* src/cubic_false_position_root_core.sv */
// Top level of the cubic false-position root finder.
// Finds one root of a*x^3+b*x^2+c*x+d (signed Q12.20, saturating) inside the bracket
// given on the s_ channel and returns the last chord crossing (or zero when the ends
// have no sign change), a status and the step count on the m_ channel. One bracket is
// processed at a time. The core takes the bracket, evaluates both ends and checks the
// sign change; each chord step then runs two multiplies, a numerator step, a
// bit-per-cycle restoring divide, a quotient step, a Horner evaluation on the one shared
// 32x32 multiplier and an update step. Returning a result waits until the previous one
// has been taken. Configuration writes are always accepted.
module cubic_false_position_root_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [cfpr_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
    input  logic [cfpr_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  cfpr_pkg::data_t                        s_lower_bound,
    input  cfpr_pkg::data_t                        s_upper_bound,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output cfpr_pkg::data_t                        m_root_estimate,
    output logic [1:0]                             m_status,
    output logic [cfpr_pkg::LIMIT_WIDTH-1:0]       m_iterations_used
);
    import cfpr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t dp_status;
    logic       cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    cfpr_ctrl u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_iterations_used (m_iterations_used),
        .cmd               (cmd),
        .status            (dp_status)
    );

    cfpr_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .lower_bound (s_lower_bound),
        .upper_bound (s_upper_bound),
        .cmd         (cmd),
        .status      (dp_status),
        .root        (m_root_estimate)
    );

endmodule

/* tb/cubic_false_position_root_core_test.sv */
// Self-checking testbench of the cubic false-position root finder core.
`timescale 1ns / 100ps

module cubic_false_position_root_core_test;
    import cfpr_pkg::*;

    localparam longint VAL_MAX = 64'sd2147483647;
    localparam longint VAL_MIN = -64'sd2147483648;
    localparam int ONE = 1 << FRACTION_BITS;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        data_t   root;
        status_t status;
        logic [LIMIT_WIDTH-1:0] steps;
    } root_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    data_t s_lower_bound = '0;
    data_t s_upper_bound = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    data_t m_root_estimate;
    logic [1:0] m_status;
    logic [LIMIT_WIDTH-1:0] m_iterations_used;

    longint cf_cubic, cf_square, cf_linear, cf_constant, tol;
    int unsigned step_limit;
    root_result_t pending_roots[$];
    int errors = 0;
    int cycles = 0;
    bit no_gaps = 0;

    cubic_false_position_root_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_lower_bound(s_lower_bound), .s_upper_bound(s_upper_bound),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_root_estimate(m_root_estimate), .m_status(m_status),
        .m_iterations_used(m_iterations_used)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint sat_val(bit neg, logic [127:0] mag);
        if (neg) begin
            if (mag > 128'd2147483648) return VAL_MIN;
            return -longint'(mag[63:0]);
        end
        if (mag > 128'd2147483647) return VAL_MAX;
        return longint'(mag[63:0]);
    endfunction

    function automatic logic [127:0] mag_of(longint v);
        return (v < 0) ? 128'(-v) : 128'(v);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        return sat_val((a < 0) != (b < 0), (mag_of(a) * mag_of(b)) >> FRACTION_BITS);
    endfunction

    function automatic longint sat_add(longint a, longint b);
        longint s;
        s = a + b;
        if (s > VAL_MAX) return VAL_MAX;
        if (s < VAL_MIN) return VAL_MIN;
        return s;
    endfunction

    function automatic longint cubic_at(longint x);
        longint y;
        y = sat_add(fx_mul(cf_cubic, x), cf_square);
        y = sat_add(fx_mul(y, x), cf_linear);
        return sat_add(fx_mul(y, x), cf_constant);
    endfunction

    function automatic longint chord_cross(longint x1, longint f1, longint x2, longint f2);
        logic [127:0] p, q, num, dm;
        bit pn, qn, nn, dn;
        p = mag_of(x1) * mag_of(f2);
        q = mag_of(x2) * mag_of(f1);
        pn = (x1 < 0) != (f2 < 0);
        qn = (x2 < 0) != (f1 < 0);
        if (pn != qn) begin
            num = p + q;
            nn = pn;
        end else if (p >= q) begin
            num = p - q;
            nn = pn;
        end else begin
            num = q - p;
            nn = !pn;
        end
        dn = f2 < f1;
        dm = mag_of(f2 - f1);
        if (dm == 0) return x2;
        return sat_val(nn != dn, num / dm);
    endfunction

    function automatic root_result_t solve_bracket(longint x1, longint x2);
        root_result_t r;
        longint f1, f2, x, y;
        int unsigned n;
        f1 = cubic_at(x1);
        f2 = cubic_at(x2);
        n = 0;
        if ((f1 >= 0 && f2 >= 0) || (f1 <= 0 && f2 <= 0)) begin
            r.root = '0;
            r.status = ST_NO_BRACKET;
            r.steps = '0;
            return r;
        end
        forever begin
            x = chord_cross(x1, f1, x2, f2);
            y = cubic_at(x);
            n++;
            if ((y > 0 && f1 > 0) || (y < 0 && f1 < 0)) begin
                x1 = x;
                f1 = y;
            end else begin
                x2 = x;
                f2 = y;
            end
            if (y >= 0 ? (y < tol) : (y > -tol)) begin
                r.status = ST_CONVERGED;
                break;
            end
            if (n >= step_limit) begin
                r.status = ST_LIMIT;
                break;
            end
        end
        r.root = data_t'(x);
        r.steps = n[LIMIT_WIDTH-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("cubic_false_position_root_core regression: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        root_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_roots.size() == 0) begin
                $error("unexpected result root_estimate=%0d", m_root_estimate);
                errors++;
            end else begin
                exp_r = pending_roots.pop_front();
                if (m_root_estimate !== exp_r.root) begin
                    $error("root_estimate expected %0d actual %0d", exp_r.root,
                           m_root_estimate);
                    errors++;
                end
                if (m_status !== exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status, m_status);
                    errors++;
                end
                if (m_iterations_used !== exp_r.steps) begin
                    $error("iterations_used expected %0d actual %0d", exp_r.steps,
                           m_iterations_used);
                    errors++;
                end
            end
        end
    end

    // result side: unless no_gaps is set, drop m_ready for a random stall before each transfer
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_COEFF_CUBIC:     cf_cubic = longint'(signed'(value));
            REG_COEFF_SQUARE:    cf_square = longint'(signed'(value));
            REG_COEFF_LINEAR:    cf_linear = longint'(signed'(value));
            REG_COEFF_CONSTANT:  cf_constant = longint'(signed'(value));
            REG_TOLERANCE:       tol = longint'(value[30:0]);
            REG_ITERATION_LIMIT: step_limit = value[7:0];
            default: ;
        endcase
    endtask

    task automatic set_cubic(int a, int b, int c, int d);
        write_reg(REG_COEFF_CUBIC, a);
        write_reg(REG_COEFF_SQUARE, b);
        write_reg(REG_COEFF_LINEAR, c);
        write_reg(REG_COEFF_CONSTANT, d);
    endtask

    task automatic send_bracket(int lo, int hi);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_lower_bound <= lo;
        s_upper_bound <= hi;
        do @(posedge aclk); while (!s_ready);
        pending_roots.push_back(solve_bracket(longint'(lo), longint'(hi)));
    endtask

    // hold off until every result has been taken and the core is idle
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_roots.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic test_reset_defaults;
        send_bracket(-ONE, ONE);
        send_bracket(int'(VAL_MIN), int'(VAL_MAX));
        drain();
    endtask

    task automatic test_known_cubic;
        set_cubic(ONE, 0, -ONE, 0);
        send_bracket(ONE / 2, 2 * ONE);
        send_bracket(-2 * ONE, -ONE / 2);
        send_bracket(2 * ONE, ONE / 2);
        send_bracket(0, 2 * ONE);
        send_bracket(int'(VAL_MIN), int'(VAL_MAX));
        send_bracket(int'(VAL_MAX), int'(VAL_MIN));
        send_bracket(3 * ONE, 5 * ONE);
        drain();
    endtask

    task automatic test_zero_tolerance;
        write_reg(REG_TOLERANCE, 0);
        write_reg(REG_ITERATION_LIMIT, 8);
        send_bracket(ONE / 2, 3 * ONE);
        send_bracket(-3 * ONE, -ONE / 3);
        drain();
        write_reg(REG_TOLERANCE, 32'h7fff_ffff);
        send_bracket(ONE / 2, 3 * ONE);
        drain();
    endtask

    task automatic test_limit_edges;
        write_reg(REG_TOLERANCE, 1);
        write_reg(REG_ITERATION_LIMIT, 1);
        send_bracket(ONE / 2, 3 * ONE);
        drain();
        write_reg(REG_ITERATION_LIMIT, 0);
        send_bracket(ONE / 2, 3 * ONE);
        drain();
        write_reg(REG_ITERATION_LIMIT, 255);
        write_reg(REG_TOLERANCE, 0);
        send_bracket(ONE / 2, 3 * ONE);
        drain();
    endtask

    task automatic test_coeff_extremes;
        write_reg(REG_TOLERANCE, 10);
        write_reg(REG_ITERATION_LIMIT, 64);
        set_cubic(int'(VAL_MAX), int'(VAL_MIN), int'(VAL_MAX), int'(VAL_MIN));
        send_bracket(-ONE, ONE);
        send_bracket(int'(VAL_MIN), int'(VAL_MAX));
        drain();
        set_cubic(int'(VAL_MIN), int'(VAL_MAX), int'(VAL_MIN), int'(VAL_MAX));
        send_bracket(-4 * ONE, 4 * ONE);
        send_bracket(0, int'(VAL_MAX));
        drain();
    endtask

    task automatic test_random_brackets;
        int x1, x2, n;
        for (int phase = 0; phase < 8; phase++) begin
            set_cubic(int'($urandom_range(0, 4 * ONE)) - 2 * ONE,
                      int'($urandom_range(0, 16 * ONE)) - 8 * ONE,
                      int'($urandom_range(0, 16 * ONE)) - 8 * ONE,
                      int'($urandom_range(0, 16 * ONE)) - 8 * ONE);
            write_reg(REG_TOLERANCE, $urandom_range(0, 3) == 0 ? 10 :
                      $urandom_range(1, 1 << 14));
            write_reg(REG_ITERATION_LIMIT, $urandom_range(4, 64));
            no_gaps = (phase % 3 == 2);
            n = 0;
            while (n < 25) begin
                if ($urandom_range(0, 6) == 0) begin
                    x1 = $urandom;
                    x2 = $urandom;
                end else begin
                    x1 = int'($urandom_range(0, 16 * ONE)) - 8 * ONE;
                    x2 = int'($urandom_range(0, 16 * ONE)) - 8 * ONE;
                end
                send_bracket(x1, x2);
                n++;
                if (n == 12) drain();
            end
            drain();
        end
        no_gaps = 0;
    endtask

    initial begin
        cf_cubic = 0;
        cf_square = 0;
        cf_linear = 0;
        cf_constant = 0;
        tol = TOL_RESET;
        step_limit = LIMIT_RESET;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_known_cubic();
        test_zero_tolerance();
        test_limit_edges();
        test_coeff_extremes();
        test_random_brackets();
        drain();
        if (errors == 0) begin
            $display("cubic_false_position_root_core regression: pass");
        end else begin
            $display("cubic_false_position_root_core regression: fail");
        end
        $finish;
    end

endmodule
